[rtl/ydpw_pkg.sv]
// shared types, constants and helpers for the yuy2 dark pixel whitening pipeline
// no dependencies
package ydpw_pkg;

  localparam int SumW  = 26;
  localparam int FracW = 14;

  typedef logic [7:0]             pix_t;
  typedef logic signed [SumW-1:0] sum_t;

  typedef struct packed {
    pix_t r;
    pix_t g;
    pix_t b;
  } rgb_t;

  // configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_DARK_THRESHOLD = 1'b0;
  localparam cfg_idx_t REG_FILL_VALUE     = 1'b1;

  localparam logic [8:0] DARK_THRESHOLD_RST = 9'd50;
  localparam pix_t       FILL_VALUE_RST     = 8'd255;

  // signed q2.14 coefficients
  localparam sum_t K_RV  = 26'sd23060;
  localparam sum_t K_GU  = 26'sd5661;
  localparam sum_t K_GV  = 26'sd11746;
  localparam sum_t K_BU  = 26'sd29147;
  localparam sum_t K_YR  = 26'sd4914;
  localparam sum_t K_YG  = 26'sd9617;
  localparam sum_t K_YB  = 26'sd1868;
  localparam sum_t K_UR  = 26'sd2764;
  localparam sum_t K_UG  = 26'sd5428;
  localparam sum_t K_HALF = 26'sd8192;
  localparam sum_t K_VG  = 26'sd6860;
  localparam sum_t K_VB  = 26'sd1332;
  localparam sum_t OFFSET_128 = 26'sd2097152;

  // negative to zero, floor, saturate at 255
  function automatic pix_t to_byte(input sum_t q);
    logic [SumW-FracW-1:0] f;
    pix_t                  res;
    f = q[SumW-1:FracW];
    if (q[SumW-1]) begin
      res = '0;
    end else if (f > 12'd255) begin
      res = 8'd255;
    end else begin
      res = f[7:0];
    end
    return res;
  endfunction

  function automatic sum_t ext_pix(input pix_t p);
    return $signed({{(SumW-8){1'b0}}, p});
  endfunction

endpackage

[rtl/ydpw_rgb_unit.sv]
// two-stage yuv to rgb conversion of one pixel with shared chroma
// depends on ydpw_pkg
module ydpw_rgb_unit
  import ydpw_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  pix_t y,
  input  pix_t u,
  input  pix_t v,
  output rgb_t rgb_r
);

  sum_t u_s;
  sum_t v_s;
  sum_t yq_r, pr_r, pgu_r, pgv_r, pb_r;
  rgb_t rgb_nxt;

  // remove the 128 chroma offset
  assign u_s = ext_pix(u) - 26'sd128;
  assign v_s = ext_pix(v) - 26'sd128;

  always_ff @(posedge clk) begin
    if (en) begin
      yq_r  <= ext_pix(y) <<< FracW;
      pr_r  <= v_s * K_RV;
      pgu_r <= u_s * K_GU;
      pgv_r <= v_s * K_GV;
      pb_r  <= u_s * K_BU;
    end
  end

  always_comb begin
    rgb_nxt.r = to_byte(yq_r + pr_r);
    rgb_nxt.g = to_byte(yq_r - pgu_r - pgv_r);
    rgb_nxt.b = to_byte(yq_r + pb_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgb_r <= rgb_nxt;
    end
  end

endmodule

[rtl/yuy2_dark_pixel_whiten.sv]
// top level: yuy2 macropixel to rgb, dark pixel fill, back to yuv
// depends on ydpw_pkg and ydpw_rgb_unit
//
//  channel | ports                                   | beat
//  in      | in_valid/in_ready, y0 u y1 v bytes      | one macropixel
//  out     | out_valid/out_ready, y0 u y1 v bytes    | one processed macropixel
//  cfg     | cfg_we, cfg_index, cfg_wdata            | one register write
//
// five register stages: chroma products, rgb clamp, whitening, back-conversion
// products, sums and clamp into the output register. one beat per cycle unless
// stalled: the whole pipeline holds while the output beat waits. in_ready is
// combinationally high when the output register is empty or out_ready is high;
// a synchronous active-low reset clears valid bits, sets threshold 50, fill 255.
module yuy2_dark_pixel_whiten
  import ydpw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_luma_first,
  input  logic [7:0] in_chroma_blue,
  input  logic [7:0] in_luma_second,
  input  logic [7:0] in_chroma_red,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_luma_first_out,
  output logic [7:0] out_chroma_blue_out,
  output logic [7:0] out_luma_second_out,
  output logic [7:0] out_chroma_red_out,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [8:0] cfg_wdata
);

  logic       adv;
  logic [4:0] vld_r;
  logic [8:0] thr_r;
  pix_t       fill_r;

  rgb_t p0_rgb, p1_rgb;
  rgb_t p0_w_r, p1_w_r, p0_w_nxt, p1_w_nxt;
  sum_t y0r_r, y0g_r, y0b_r, y1r_r, y1g_r, y1b_r;
  sum_t ur_r, ug_r, ub_r, vr_r, vg_r, vb_r;
  pix_t o_y0_r, o_u_r, o_y1_r, o_v_r;

  assign adv      = !vld_r[4] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= DARK_THRESHOLD_RST;
      fill_r <= FILL_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DARK_THRESHOLD: thr_r  <= cfg_wdata;
        REG_FILL_VALUE:     fill_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  ydpw_rgb_unit u_rgb0 (
    .clk   (clk),
    .en    (adv),
    .y     (in_luma_first),
    .u     (in_chroma_blue),
    .v     (in_chroma_red),
    .rgb_r (p0_rgb)
  );

  ydpw_rgb_unit u_rgb1 (
    .clk   (clk),
    .en    (adv),
    .y     (in_luma_second),
    .u     (in_chroma_blue),
    .v     (in_chroma_red),
    .rgb_r (p1_rgb)
  );

  // dark when all three channels sit strictly below the threshold
  function automatic rgb_t whiten(input rgb_t p, input logic [8:0] thr, input pix_t fill);
    rgb_t res;
    if (({1'b0, p.r} < thr) && ({1'b0, p.g} < thr) && ({1'b0, p.b} < thr)) begin
      res = '{r: fill, g: fill, b: fill};
    end else begin
      res = p;
    end
    return res;
  endfunction

  assign p0_w_nxt = whiten(p0_rgb, thr_r, fill_r);
  assign p1_w_nxt = whiten(p1_rgb, thr_r, fill_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_w_r <= p0_w_nxt;
      p1_w_r <= p1_w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y0r_r <= ext_pix(p0_w_r.r) * K_YR;
      y0g_r <= ext_pix(p0_w_r.g) * K_YG;
      y0b_r <= ext_pix(p0_w_r.b) * K_YB;
      y1r_r <= ext_pix(p1_w_r.r) * K_YR;
      y1g_r <= ext_pix(p1_w_r.g) * K_YG;
      y1b_r <= ext_pix(p1_w_r.b) * K_YB;
      ur_r  <= ext_pix(p0_w_r.r) * K_UR;
      ug_r  <= ext_pix(p0_w_r.g) * K_UG;
      ub_r  <= ext_pix(p0_w_r.b) * K_HALF;
      vr_r  <= ext_pix(p0_w_r.r) * K_HALF;
      vg_r  <= ext_pix(p0_w_r.g) * K_VG;
      vb_r  <= ext_pix(p0_w_r.b) * K_VB;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_y0_r <= to_byte(y0r_r + y0g_r + y0b_r);
      o_y1_r <= to_byte(y1r_r + y1g_r + y1b_r);
      o_u_r  <= to_byte(ub_r - ur_r - ug_r + OFFSET_128);
      o_v_r  <= to_byte(vr_r - vg_r - vb_r + OFFSET_128);
    end
  end

  assign out_valid           = vld_r[4];
  assign out_luma_first_out  = o_y0_r;
  assign out_chroma_blue_out = o_u_r;
  assign out_luma_second_out = o_y1_r;
  assign out_chroma_red_out  = o_v_r;

endmodule
